// ===== rtl/core/rnp_pkg.sv =====
// Shared types, character codes and mode codes of the radix number parser.
package rnp_pkg;

    localparam int ACC_W       = 64;
    localparam int HALF_W      = 32;
    localparam int CHAR_W      = 8;
    localparam int MODE_W      = 3;
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 3;
    localparam int DIGIT_W     = 4;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] CFG_PARSE_MODE  = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_WIDE_RESULT = 1'd1;

    // Parse mode codes.
    localparam logic [MODE_W-1:0] MODE_AUTO   = 3'd0;
    localparam logic [MODE_W-1:0] MODE_BIN    = 3'd1;
    localparam logic [MODE_W-1:0] MODE_OCT    = 3'd2;
    localparam logic [MODE_W-1:0] MODE_DEC    = 3'd3;
    localparam logic [MODE_W-1:0] MODE_HEX    = 3'd4;
    localparam logic [MODE_W-1:0] MODE_SIGNED = 3'd5;

    localparam logic [MODE_W-1:0]  MODE_RESET = MODE_AUTO;
    localparam logic               WIDE_RESET = 1'b1;

    // Character codes.
    localparam logic [CHAR_W-1:0] CHAR_ZERO       = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_UNDERSCORE = 8'h5f;
    localparam logic [CHAR_W-1:0] CHAR_APOSTROPHE = 8'h27;
    localparam logic [CHAR_W-1:0] CHAR_HEX_GAP    = 8'h27;  // 'a' minus ':'
    localparam logic [CHAR_W-1:0] CHAR_LOWER_X    = 8'h78;
    localparam logic [CHAR_W-1:0] CHAR_LOWER_B    = 8'h62;
    localparam logic [CHAR_W-1:0] CHAR_LOWER_A    = 8'h61;
    localparam logic [CHAR_W-1:0] CHAR_LOWER_F    = 8'h66;
    localparam logic [CHAR_W-1:0] CHAR_MINUS      = 8'h2d;
    localparam logic [CHAR_W-1:0] CHAR_PLUS       = 8'h2b;

    typedef enum logic [3:0] {
        PH_START    = 4'b0001,
        PH_ZERO     = 4'b0010,
        PH_UNSIGNED = 4'b0100,
        PH_SIGNED   = 4'b1000
    } phase_t;

    typedef enum logic [1:0] {
        RX_BIN = 2'd0,
        RX_OCT = 2'd1,
        RX_DEC = 2'd2,
        RX_HEX = 2'd3
    } radix_t;

    typedef struct packed {
        logic [ACC_W-1:0] acc;
        phase_t           phase;
        radix_t           radix;
        logic             negative;
        logic             stopped;
    } parse_state_t;

    localparam parse_state_t STATE_CLEAR = '{
        acc:      '0,
        phase:    PH_START,
        radix:    RX_DEC,
        negative: 1'b0,
        stopped:  1'b0
    };

endpackage

// ===== rtl/core/rnp_stream_if.sv =====
// Valid/ready stream interfaces for the character and result channels.
interface rnp_char_if;
    logic                       valid;
    logic                       ready;
    logic [rnp_pkg::CHAR_W-1:0] char_code;
    logic                       last_char;

    modport source (output valid, output char_code, output last_char, input ready);
    modport sink   (input valid, input char_code, input last_char, output ready);
endinterface

interface rnp_value_if;
    logic                      valid;
    logic                      ready;
    logic [rnp_pkg::ACC_W-1:0] parsed_value;

    modport source (output valid, output parsed_value, input ready);
    modport sink   (input valid, input parsed_value, output ready);
endinterface

// ===== rtl/core/rnp_step.sv =====
// Next-state and result logic for one character of the number string.
module rnp_step (
    input  rnp_pkg::parse_state_t        cur_state,
    input  logic [rnp_pkg::CHAR_W-1:0]   char_code,
    input  logic                         last_char,
    input  logic [rnp_pkg::MODE_W-1:0]   parse_mode,
    input  logic                         wide_result,
    output rnp_pkg::parse_state_t        next_state,
    output logic [rnp_pkg::ACC_W-1:0]    result_value
);

    rnp_pkg::parse_state_t      upd;
    rnp_pkg::radix_t            mode_radix;
    logic                       take_unsigned;
    logic                       take_signed;
    logic [rnp_pkg::CHAR_W-1:0] offset;
    logic [rnp_pkg::CHAR_W-1:0] letter_offset;
    logic                       is_letter;
    logic                       digit_ok;
    logic [rnp_pkg::DIGIT_W-1:0] digit;
    logic [rnp_pkg::ACC_W-1:0]  digit_ext;
    logic [rnp_pkg::ACC_W-1:0]  scaled;
    logic                       skip;
    logic                       active;
    logic [rnp_pkg::HALF_W-1:0] upper;

    always_comb
    begin
        unique case (parse_mode)
            rnp_pkg::MODE_BIN: mode_radix = rnp_pkg::RX_BIN;
            rnp_pkg::MODE_OCT: mode_radix = rnp_pkg::RX_OCT;
            rnp_pkg::MODE_HEX: mode_radix = rnp_pkg::RX_HEX;
            default:           mode_radix = rnp_pkg::RX_DEC;
        endcase
    end

    // Phase handling: decides the radix and which kind of digit this character is.
    always_comb
    begin
        upd           = cur_state;
        take_unsigned = 1'b0;
        take_signed   = 1'b0;
        unique case (cur_state.phase)
            rnp_pkg::PH_START:
            begin
                if (parse_mode == rnp_pkg::MODE_AUTO)
                begin
                    if (char_code == rnp_pkg::CHAR_ZERO)
                    begin
                        upd.phase = rnp_pkg::PH_ZERO;
                    end
                    else
                    begin
                        upd.radix     = rnp_pkg::RX_DEC;
                        upd.phase     = rnp_pkg::PH_UNSIGNED;
                        take_unsigned = 1'b1;
                    end
                end
                else if (parse_mode == rnp_pkg::MODE_SIGNED)
                begin
                    upd.radix = rnp_pkg::RX_DEC;
                    upd.phase = rnp_pkg::PH_SIGNED;
                    if (char_code == rnp_pkg::CHAR_MINUS)
                    begin
                        upd.negative = 1'b1;
                    end
                    else if (char_code != rnp_pkg::CHAR_PLUS)
                    begin
                        take_signed = 1'b1;
                    end
                end
                else
                begin
                    upd.radix     = mode_radix;
                    upd.phase     = rnp_pkg::PH_UNSIGNED;
                    take_unsigned = 1'b1;
                end
            end
            rnp_pkg::PH_ZERO:
            begin
                upd.phase = rnp_pkg::PH_UNSIGNED;
                if (char_code == rnp_pkg::CHAR_LOWER_X)
                begin
                    upd.radix = rnp_pkg::RX_HEX;
                end
                else if (char_code == rnp_pkg::CHAR_LOWER_B)
                begin
                    upd.radix = rnp_pkg::RX_BIN;
                end
                else
                begin
                    upd.radix     = rnp_pkg::RX_OCT;
                    take_unsigned = 1'b1;
                end
            end
            rnp_pkg::PH_SIGNED:   take_signed   = 1'b1;
            rnp_pkg::PH_UNSIGNED: take_unsigned = 1'b1;
            default:              upd.phase     = rnp_pkg::PH_START;
        endcase
    end

    // Digit decode against the radix in force after this character.
    assign offset        = char_code - rnp_pkg::CHAR_ZERO;
    assign letter_offset = offset - rnp_pkg::CHAR_HEX_GAP;
    assign is_letter     = (char_code >= rnp_pkg::CHAR_LOWER_A)
                         && (char_code <= rnp_pkg::CHAR_LOWER_F);

    always_comb
    begin
        digit = offset[rnp_pkg::DIGIT_W-1:0];
        unique case (upd.radix)
            rnp_pkg::RX_BIN: digit_ok = (offset <= 8'd1);
            rnp_pkg::RX_OCT: digit_ok = (offset <= 8'd7);
            rnp_pkg::RX_DEC: digit_ok = (offset <= 8'd9);
            rnp_pkg::RX_HEX:
            begin
                digit_ok = (offset <= 8'd9) || is_letter;
                if ((offset > 8'd9) && is_letter)
                begin
                    digit = letter_offset[rnp_pkg::DIGIT_W-1:0];
                end
            end
            default: digit_ok = 1'b0;
        endcase
    end

    always_comb
    begin
        unique case (upd.radix)
            rnp_pkg::RX_BIN: scaled = cur_state.acc << 1;
            rnp_pkg::RX_OCT: scaled = cur_state.acc << 3;
            rnp_pkg::RX_DEC: scaled = (cur_state.acc << 3) + (cur_state.acc << 1);
            rnp_pkg::RX_HEX: scaled = cur_state.acc << 4;
            default:         scaled = cur_state.acc;
        endcase
    end

    // A negative number is kept negated, so each digit is subtracted instead of added.
    assign digit_ext = upd.negative
                     ? ('0 - {{(rnp_pkg::ACC_W-rnp_pkg::DIGIT_W){1'b0}}, digit})
                     : {{(rnp_pkg::ACC_W-rnp_pkg::DIGIT_W){1'b0}}, digit};

    assign skip   = take_unsigned && ((char_code == rnp_pkg::CHAR_UNDERSCORE)
                                   || (char_code == rnp_pkg::CHAR_APOSTROPHE));
    assign active = (take_unsigned || take_signed) && !cur_state.stopped && !skip;

    always_comb
    begin
        next_state = upd;
        if (active)
        begin
            if (digit_ok)
            begin
                next_state.acc = scaled + digit_ext;
            end
            else
            begin
                next_state.stopped = 1'b1;
            end
        end
        if (last_char)
        begin
            next_state = rnp_pkg::STATE_CLEAR;
        end
    end

    always_comb
    begin
        result_value = upd.acc;
        if (active && digit_ok)
        begin
            result_value = scaled + digit_ext;
        end
        upper = ((upd.phase == rnp_pkg::PH_SIGNED) && result_value[rnp_pkg::HALF_W-1])
              ? '1 : '0;
        if (!wide_result)
        begin
            result_value = {upper, result_value[rnp_pkg::HALF_W-1:0]};
        end
    end

endmodule

// ===== rtl/core/radix_number_parser.sv =====
// Top level of the streaming radix number parser.
//
// The chars channel carries one ASCII character per word, with last_char set
// on the final character of a string. The values channel delivers one word,
// parsed_value, for every string, formed on the character flagged last.
// Characters that are not last give no result word.
//
// Configuration is a plain write port: cfg_we with cfg_index 0 writes
// parse_mode, index 1 writes wide_result. Writes belong to idle time only.
// parse_mode is sampled at the first character of a string, wide_result when
// the result is formed.
//
// An accepted character is held in the input register until it is folded into
// the parse state, and a last character puts its result into the output
// register at that same edge. Throughput is one character per cycle, set by
// the single multiply-by-radix-and-add path, while no stalled result blocks it.
//
// Reset clears the parse state, restores the registers to auto mode and
// 64-bit results, and empties both registers. When the receiver stalls, the
// result stays in the output register; a following last character waits in
// the input register and chars.ready drops until the result is taken.
module radix_number_parser (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [rnp_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [rnp_pkg::CFG_DATA_W-1:0]    cfg_data,
    rnp_char_if.sink                          chars,
    rnp_value_if.source                       values
);

    logic [rnp_pkg::MODE_W-1:0] mode_reg;
    logic                       wide_reg;

    logic                       s1_valid_reg;
    logic                       s1_valid_next;
    logic [rnp_pkg::CHAR_W-1:0] s1_char_reg;
    logic                       s1_last_reg;

    rnp_pkg::parse_state_t      state_reg;
    rnp_pkg::parse_state_t      state_next;

    logic                       out_valid_reg;
    logic                       out_valid_next;
    logic [rnp_pkg::ACC_W-1:0]  out_value_reg;
    logic [rnp_pkg::ACC_W-1:0]  step_value;

    logic                       in_accept;
    logic                       advance;

    // A character that gives no result can always move on; a last character
    // needs room in the output register.
    assign advance   = s1_valid_reg && (!s1_last_reg || !out_valid_reg || values.ready);
    assign in_accept = chars.valid && chars.ready;

    assign chars.ready         = !s1_valid_reg || advance;
    assign values.valid        = out_valid_reg;
    assign values.parsed_value = out_value_reg;

    rnp_step u_step (
        .cur_state    (state_reg),
        .char_code    (s1_char_reg),
        .last_char    (s1_last_reg),
        .parse_mode   (mode_reg),
        .wide_result  (wide_reg),
        .next_state   (state_next),
        .result_value (step_value)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= rnp_pkg::MODE_RESET;
            wide_reg <= rnp_pkg::WIDE_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                rnp_pkg::CFG_PARSE_MODE:  mode_reg <= cfg_data;
                rnp_pkg::CFG_WIDE_RESULT: wide_reg <= cfg_data[0];
                default:                  mode_reg <= mode_reg;
            endcase
        end
    end

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (advance)
        begin
            s1_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (advance && s1_last_reg)
        begin
            out_valid_next = 1'b1;
        end
        else if (values.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= rnp_pkg::STATE_CLEAR;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            if (advance)
            begin
                state_reg <= state_next;
            end
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_char_reg <= chars.char_code;
            s1_last_reg <= chars.last_char;
        end
        if (advance && s1_last_reg)
        begin
            out_value_reg <= step_value;
        end
    end

    // After a last character is folded in, the parser is back at its start state.
    a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && s1_last_reg) |=> (state_reg.phase == rnp_pkg::PH_START
                                      && state_reg.acc == '0))
        else $error("parse state not cleared after last character");

    // The input side stalls only behind a last character facing a stalled result.
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !chars.ready |-> (s1_valid_reg && s1_last_reg && out_valid_reg && !values.ready))
        else $error("input stalled without a blocked result");

    // At the start of a string nothing has been gathered yet.
    a_start_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg.phase == rnp_pkg::PH_START) |->
            (state_reg.acc == '0 && !state_reg.negative && !state_reg.stopped))
        else $error("start phase holds stale parse state");

    // Only signed decimal parsing may carry a negative sign.
    a_negative_signed: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.negative |-> (state_reg.phase == rnp_pkg::PH_SIGNED))
        else $error("negative flag outside signed parsing");

endmodule

// ===== tb/rnp_checker.sv =====
`timescale 1ns / 1ps
// Checker that predicts every parsed value and compares it with the values channel.
module rnp_checker
    import rnp_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    rnp_char_if                    chars,
    rnp_value_if                   values,
    output int unsigned            errors,
    output int unsigned            waiting,
    output int unsigned            words_checked
);

    logic [MODE_W-1:0] mode_reg;
    logic              wide_reg;

    logic [ACC_W-1:0]  acc;
    phase_t            phase;
    radix_t            radix;
    logic              neg;
    logic              stopped;

    logic [ACC_W-1:0]  expected_values[$];

    task automatic clear_string();
        acc     = '0;
        phase   = PH_START;
        radix   = RX_DEC;
        neg     = 1'b0;
        stopped = 1'b0;
    endtask

    task automatic take_unsigned(input logic [CHAR_W-1:0] c);
        logic [CHAR_W-1:0] n;
        logic [4:0]        base;
        logic              ok;
        if (stopped || c == CHAR_UNDERSCORE || c == CHAR_APOSTROPHE)
            return;
        n = c - CHAR_ZERO;
        case (radix)
            RX_BIN:
            begin
                base = 5'd2;
                ok   = (n <= 8'd1);
            end
            RX_OCT:
            begin
                base = 5'd8;
                ok   = (n <= 8'd7);
            end
            RX_DEC:
            begin
                base = 5'd10;
                ok   = (n <= 8'd9);
            end
            default:
            begin
                base = 5'd16;
                ok   = (n <= 8'd9);
                // Only lowercase letters count as hex digits.
                if (!ok && c >= CHAR_LOWER_A && c <= CHAR_LOWER_F)
                begin
                    n  = c - CHAR_LOWER_A + 8'd10;
                    ok = 1'b1;
                end
            end
        endcase
        if (!ok)
            stopped = 1'b1;
        else
            acc = acc * base + n;
    endtask

    task automatic take_signed(input logic [CHAR_W-1:0] c);
        if (stopped)
            return;
        if (c >= CHAR_ZERO && c <= CHAR_ZERO + 8'd9)
            acc = acc * 64'd10 + (c - CHAR_ZERO);
        else
            stopped = 1'b1;
    endtask

    task automatic fold_char(input logic [CHAR_W-1:0] c, input logic last);
        logic [ACC_W-1:0] v;
        case (phase)
            PH_START:
            begin
                // The mode is sampled here, at the first character of a string.
                if (mode_reg == MODE_AUTO)
                begin
                    if (c == CHAR_ZERO)
                        phase = PH_ZERO;
                    else
                    begin
                        radix = RX_DEC;
                        phase = PH_UNSIGNED;
                        take_unsigned(c);
                    end
                end
                else if (mode_reg == MODE_SIGNED)
                begin
                    radix = RX_DEC;
                    phase = PH_SIGNED;
                    if (c == CHAR_MINUS)
                        neg = 1'b1;
                    else if (c != CHAR_PLUS)
                        take_signed(c);
                end
                else
                begin
                    case (mode_reg)
                        MODE_BIN: radix = RX_BIN;
                        MODE_OCT: radix = RX_OCT;
                        MODE_HEX: radix = RX_HEX;
                        default:  radix = RX_DEC;
                    endcase
                    phase = PH_UNSIGNED;
                    take_unsigned(c);
                end
            end
            PH_ZERO:
            begin
                phase = PH_UNSIGNED;
                if (c == CHAR_LOWER_X)
                    radix = RX_HEX;
                else if (c == CHAR_LOWER_B)
                    radix = RX_BIN;
                else
                begin
                    radix = RX_OCT;
                    take_unsigned(c);
                end
            end
            PH_SIGNED: take_signed(c);
            default:   take_unsigned(c);
        endcase

        if (last)
        begin
            v = neg ? -acc : acc;
            if (!wide_reg)
            begin
                v = {{HALF_W{1'b0}}, v[HALF_W-1:0]};
                if (phase == PH_SIGNED && v[HALF_W-1])
                    v[ACC_W-1:HALF_W] = '1;
            end
            expected_values.push_back(v);
            clear_string();
        end
    endtask

    // All inputs change at the falling edge, so everything read here is settled.
    always @(posedge clk or negedge rst_n)
    begin
        logic [ACC_W-1:0] want;
        if (!rst_n)
        begin
            mode_reg = MODE_RESET;
            wide_reg = WIDE_RESET;
            clear_string();
            expected_values.delete();
            errors        = 0;
            words_checked = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_PARSE_MODE:  mode_reg = cfg_data[MODE_W-1:0];
                    CFG_WIDE_RESULT: wide_reg = cfg_data[0];
                    default: ;
                endcase
            end

            if (values.valid && values.ready)
            begin
                words_checked++;
                if (expected_values.size() == 0)
                begin
                    $error("parsed_value: expected no word, got 0x%016h", values.parsed_value);
                    errors++;
                end
                else
                begin
                    want = expected_values.pop_front();
                    if (values.parsed_value !== want)
                    begin
                        $error("parsed_value: expected 0x%016h, got 0x%016h",
                               want, values.parsed_value);
                        errors++;
                    end
                end
            end

            if (chars.valid && chars.ready)
                fold_char(chars.char_code, chars.last_char);
        end
        waiting = expected_values.size();
    end

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// Top of the radix number parser testbench: stimulus, idling phases and verdict.
module tb;
    import rnp_pkg::*;

    typedef logic [CHAR_W-1:0] text_t[$];

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    rnp_char_if  chars();
    rnp_value_if values();

    // Percent chances, per cycle, that the sender idles and that the receiver stalls.
    int unsigned gap_pct;
    int unsigned stall_pct;

    int unsigned char_total;
    int unsigned string_total;
    int unsigned errors;
    int unsigned waiting;
    int unsigned words_checked;
    logic [7:0]  modes_seen;
    logic [1:0]  widths_seen;

    // The mode the parser will sample at the next string, so that the random
    // strings can be shaped to match it.
    logic [MODE_W-1:0] cur_mode;

    radix_number_parser u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .chars     (chars),
        .values    (values)
    );

    rnp_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .chars         (chars),
        .values        (values),
        .errors        (errors),
        .waiting       (waiting),
        .words_checked (words_checked)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // The slowest correct run stays well inside this bound, even with the
    // heaviest idling.
    initial
    begin
        #5ms;
        $display("radix_number_parser: mismatch");
        $finish;
    end

    // The receiver decides at every falling edge whether to take a word at the
    // next rising edge.
    initial
    begin
        values.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            values.ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    function automatic text_t to_text(input string s);
        text_t q;
        for (int i = 0; i < s.len(); i++)
            q.push_back(s[i]);
        return q;
    endfunction

    // Returns a random valid digit character in the given radix.
    function automatic logic [CHAR_W-1:0] digit_char(input radix_t rx);
        logic [3:0] d;
        case (rx)
            RX_BIN:  d = 4'($urandom_range(1));
            RX_OCT:  d = 4'($urandom_range(7));
            RX_DEC:  d = 4'($urandom_range(9));
            default: d = 4'($urandom_range(15));
        endcase
        if (d < 4'd10)
            return CHAR_ZERO + d;
        return CHAR_LOWER_A + (d - 4'd10);
    endfunction

    // Builds one number string for the given mode. Most strings are well formed
    // with random digits and separators sprinkled in; a few carry stray bytes
    // that stop the parse, and some are pure noise. Some are long enough to wrap
    // the 64-bit accumulator.
    function automatic text_t make_number(input logic [MODE_W-1:0] mode);
        text_t       q;
        radix_t      rx;
        int unsigned len;
        int unsigned roll;
        if ($urandom_range(9) == 0)
        begin
            len = $urandom_range(6, 1);
            for (int i = 0; i < len; i++)
                q.push_back(CHAR_W'($urandom_range(255)));
            return q;
        end

        case (mode)
            MODE_BIN: rx = RX_BIN;
            MODE_OCT: rx = RX_OCT;
            MODE_HEX: rx = RX_HEX;
            default:  rx = RX_DEC;
        endcase

        if (mode == MODE_AUTO)
        begin
            case ($urandom_range(3))
                0:
                begin
                    q.push_back(CHAR_ZERO);
                    q.push_back(CHAR_LOWER_X);
                    rx = RX_HEX;
                end
                1:
                begin
                    q.push_back(CHAR_ZERO);
                    q.push_back(CHAR_LOWER_B);
                    rx = RX_BIN;
                end
                2:
                begin
                    q.push_back(CHAR_ZERO);
                    rx = RX_OCT;
                end
                default:
                    q.push_back(CHAR_ZERO + CHAR_W'($urandom_range(9, 1)));
            endcase
        end
        else if (mode == MODE_SIGNED)
        begin
            case ($urandom_range(3))
                0:       q.push_back(CHAR_MINUS);
                1:       q.push_back(CHAR_PLUS);
                default: ;
            endcase
        end

        len = ($urandom_range(9) == 0) ? $urandom_range(40, 17) : $urandom_range(8);
        for (int i = 0; i < len; i++)
        begin
            roll = $urandom_range(99);
            if (roll < 5)
                q.push_back(CHAR_W'($urandom_range(255)));
            else if (roll < 12)
                q.push_back($urandom_range(1) ? CHAR_UNDERSCORE : CHAR_APOSTROPHE);
            else
                q.push_back(digit_char(rx));
        end
        if (q.size() == 0)
            q.push_back(digit_char(rx));
        return q;
    endfunction

    // Sends one string, one word per character, with random idle cycles in
    // front of each word. The last word carries last_char.
    task automatic send_text(input text_t text);
        for (int i = 0; i < text.size(); i++)
        begin
            while ($urandom_range(99) < gap_pct)
            begin
                chars.valid <= 1'b0;
                @(negedge clk);
            end
            chars.valid     <= 1'b1;
            chars.char_code <= text[i];
            chars.last_char <= (i == text.size() - 1);
            do
                @(posedge clk);
            while (!chars.ready);
            @(negedge clk);
            char_total++;
        end
        string_total++;
    endtask

    // Holds the sender off until every expected word has come back, then lets
    // the pipeline's two stages run out before anything else happens.
    task automatic wait_idle();
        chars.valid <= 1'b0;
        @(negedge clk);
        while (waiting != 0)
            @(negedge clk);
        repeat (3) @(negedge clk);
    endtask

    // Both registers are written back to back, with the write enable held high
    // across both writes.
    task automatic set_config(input logic [MODE_W-1:0] mode, input logic wide);
        wait_idle();
        cfg_we    <= 1'b1;
        cfg_index <= CFG_PARSE_MODE;
        cfg_data  <= CFG_DATA_W'(mode);
        @(negedge clk);
        cfg_index <= CFG_WIDE_RESULT;
        cfg_data  <= CFG_DATA_W'(wide);
        @(negedge clk);
        cfg_we    <= 1'b0;
        cur_mode          = mode;
        modes_seen[mode]  = 1'b1;
        widths_seen[wide] = 1'b1;
    endtask

    initial
    begin
        int unsigned phase_start;
        rst_n           = 1'b0;
        cfg_we          = 1'b0;
        cfg_index       = CFG_PARSE_MODE;
        cfg_data        = '0;
        chars.valid     = 1'b0;
        chars.char_code = '0;
        chars.last_char = 1'b0;
        gap_pct         = 0;
        stall_pct       = 0;
        char_total      = 0;
        string_total    = 0;
        modes_seen      = '0;
        widths_seen     = '0;
        cur_mode        = MODE_RESET;

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed strings. The first group runs on the reset settings: auto
        // prefix detection with 64-bit results. It covers a lone zero, a bare
        // hex prefix, a short binary literal, hex that stops at an uppercase
        // letter, an octal literal and decimal with both kinds of separator.
        modes_seen[MODE_RESET]  = 1'b1;
        widths_seen[WIDE_RESET] = 1'b1;
        send_text(to_text("0"));
        send_text(to_text("0x"));
        send_text(to_text("0b1"));
        send_text(to_text("0xaF"));
        send_text(to_text("017"));
        send_text(to_text("1_'3"));

        // Signed decimal with 32-bit results: a sign with no digits, an explicit
        // plus, and a separator that stops a signed parse.
        set_config(MODE_SIGNED, 1'b0);
        send_text(to_text("-"));
        send_text(to_text("+9"));
        send_text(to_text("-8_"));

        // An undefined mode behaves as unsigned decimal; the all-ones byte stops it.
        set_config(3'd7, 1'b1);
        send_text(to_text("\377"));

        // Random strings in four idling phases. Each phase opens on a setting
        // of its own, and the setting changes now and then between strings.
        for (int p = 0; p < 4; p++)
        begin
            case (p)
                0:
                begin
                    gap_pct   = 0;
                    stall_pct = 0;
                    set_config(MODE_AUTO, 1'b0);
                end
                1:
                begin
                    gap_pct   = 84;
                    stall_pct = 0;
                    set_config(MODE_HEX, 1'b1);
                end
                2:
                begin
                    gap_pct   = 0;
                    stall_pct = 84;
                    set_config(MODE_SIGNED, 1'b0);
                end
                default:
                begin
                    gap_pct   = 28;
                    stall_pct = 28;
                    set_config(MODE_BIN, 1'b1);
                end
            endcase
            phase_start = char_total;
            while (char_total - phase_start < 112)
            begin
                if ($urandom_range(7) == 0)
                    set_config(MODE_W'($urandom_range(7)), 1'($urandom_range(1)));
                send_text(make_number(cur_mode));
            end
        end

        wait_idle();
        $display("Run covered %0d strings in %0d characters, %0d result words checked.",
                 string_total, char_total, words_checked);
        $display("Parse modes used (bit per mode) %b, result widths used %b.",
                 modes_seen, widths_seen);
        if (errors == 0)
            $display("radix_number_parser: match");
        else
            $display("radix_number_parser: mismatch");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/core/rnp_pkg.sv
rtl/core/rnp_stream_if.sv
rtl/core/rnp_step.sv
rtl/core/radix_number_parser.sv
tb/rnp_checker.sv
tb/tb.sv
